[hdl/assert_macros.svh]
// Assertion macros used by the clipper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/cpsc_pkg.sv]
// Shared types and constants of the polygon segment clipper.
package cpsc_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS = 12;
  localparam int IDX_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS = 5;
  localparam int T_FRAC = 16;
  localparam int T_BITS = T_FRAC + 1;
  localparam int DOT_BITS = 2 * COORD_BITS + 3;
  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CLIP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DOT, ST_DIV, ST_NEXT, ST_LERP, ST_OUT
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] vx;
    logic [COORD_BITS-1:0] vy;
  } pair_t;

  typedef struct packed {
    logic start;
    logic [DOT_BITS-1:0] a;
    logic [DOT_BITS-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [T_BITS-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic kind;
    logic [IDX_BITS-1:0] vertex_index;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] normal_x;
    logic signed [COORD_BITS-1:0] normal_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic visible;
    logic signed [COORD_BITS-1:0] clip_start_x;
    logic signed [COORD_BITS-1:0] clip_start_y;
    logic signed [COORD_BITS-1:0] clip_end_x;
    logic signed [COORD_BITS-1:0] clip_end_y;
  } out_word_t;
endpackage

[hdl/cpsc_if.sv]
// Valid/ready channel interfaces of the clipper.
interface cpsc_in_if;
  logic valid;
  logic ready;
  cpsc_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cpsc_out_if;
  logic valid;
  logic ready;
  cpsc_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cpsc_cfg_if;
  logic valid;
  logic ready;
  logic [cpsc_pkg::CNT_BITS-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/convex_polygon_segment_clipper.sv]
// Top level of the convex polygon segment clipper.
// channel | dir | contents
// in      | in  | load vertex/normal or clip segment
// out     | out | visibility and clipped endpoints
// cfg     | in  | vertex_count
// A load is written in the idle state. A clip steps each edge through READ, DOT, DIV
// and NEXT, waiting in NEXT while the bit-serial divider is busy, then LERP and OUT.
// The tables are memories with registered reads, one entry pair per edge.
// Reset clears control only; the tables hold nothing until loaded.
// A held result stalls the next clip at its endpoint (LERP) stage.
`include "assert_macros.svh"
module convex_polygon_segment_clipper (
  input logic clk,
  input logic rst_n,
  cpsc_in_if.sink in_ch,
  cpsc_out_if.source out_ch,
  cpsc_cfg_if.sink cfg_ch
);
  localparam int CB = cpsc_pkg::COORD_BITS;
  localparam int IB = cpsc_pkg::IDX_BITS;
  localparam int DB = cpsc_pkg::DOT_BITS;
  localparam int TB = cpsc_pkg::T_BITS;

  cpsc_pkg::pair_t vtx_mem [cpsc_pkg::MAX_VERTICES];
  cpsc_pkg::pair_t nrm_mem [cpsc_pkg::MAX_VERTICES];
  cpsc_pkg::pair_t vi_r, vj_r, ni_r;

  cpsc_pkg::state_t state_r, state_nxt;
  logic [cpsc_pkg::CNT_BITS-1:0] count_r, n_eff;
  logic [IB-1:0] i_r;
  logic [IB-1:0] j_idx;
  logic signed [CB-1:0] sx_r, sy_r;
  logic signed [CB:0] dx_r, dy_r;
  logic signed [DB-1:0] num_r, den_r;
  logic [TB-1:0] te_r, tl_r;
  logic reject_r, out_valid_r;
  cpsc_pkg::out_word_t out_r;
  cpsc_pkg::div_req_t dreq;
  cpsc_pkg::div_rsp_t drsp;
  logic dpos_r;
  logic in_fire, last_edge, out_free;

  assign n_eff = (count_r < 5'd3) ? 5'd3 :
    (count_r > 5'(cpsc_pkg::MAX_VERTICES) ? 5'(cpsc_pkg::MAX_VERTICES) : count_r);
  assign last_edge = (5'(i_r) + 5'd1 == n_eff);
  assign j_idx = last_edge ? '0 : i_r + 1'b1;
  assign in_ch.ready = (state_r == cpsc_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.data.kind == cpsc_pkg::KIND_LOAD) begin
      vtx_mem[in_ch.data.vertex_index[IB-1:0]] <= {in_ch.data.vertex_x, in_ch.data.vertex_y};
      nrm_mem[in_ch.data.vertex_index[IB-1:0]] <= {in_ch.data.normal_x, in_ch.data.normal_y};
    end
    vi_r <= vtx_mem[i_r];
    vj_r <= vtx_mem[j_idx];
    ni_r <= nrm_mem[i_r];
  end

  logic signed [CB:0] fx, fy, wx, wy;
  logic signed [CB:0] sumx, sumy;
  always_comb begin
    sumx = $signed({vi_r.vx[CB-1], vi_r.vx}) + $signed({vj_r.vx[CB-1], vj_r.vx});
    sumy = $signed({vi_r.vy[CB-1], vi_r.vy}) + $signed({vj_r.vy[CB-1], vj_r.vy});
    fx = (sumx + $signed({{CB{1'b0}}, sumx[CB]})) >>> 1;
    fy = (sumy + $signed({{CB{1'b0}}, sumy[CB]})) >>> 1;
    wx = $signed({sx_r[CB-1], sx_r}) - fx;
    wy = $signed({sy_r[CB-1], sy_r}) - fy;
  end

  logic signed [DB-1:0] num_c, den_c, neg_num;
  always_comb begin
    num_c = DB'(wx * $signed(ni_r.vx)) + DB'(wy * $signed(ni_r.vy));
    den_c = DB'(dx_r * $signed(ni_r.vx)) + DB'(dy_r * $signed(ni_r.vy));
    neg_num = -num_r;
  end

  always_comb begin
    state_nxt = state_r;
    dreq = '0;
    case (state_r)
      cpsc_pkg::ST_IDLE:
        if (in_fire && in_ch.data.kind == cpsc_pkg::KIND_CLIP) state_nxt = cpsc_pkg::ST_READ;
      cpsc_pkg::ST_READ: state_nxt = cpsc_pkg::ST_DOT;
      cpsc_pkg::ST_DOT: state_nxt = cpsc_pkg::ST_DIV;
      cpsc_pkg::ST_DIV: begin
        state_nxt = cpsc_pkg::ST_NEXT;
        if (den_r > 0 && neg_num > 0 && neg_num < den_r) begin
          dreq.start = 1'b1;
          dreq.a = neg_num;
          dreq.b = den_r;
        end else if (den_r < 0 && num_r >= 0 && num_r < -den_r) begin
          dreq.start = 1'b1;
          dreq.a = num_r;
          dreq.b = -den_r;
        end
      end
      cpsc_pkg::ST_NEXT:
        if (!drsp.busy) state_nxt = (last_edge || reject_r) ? cpsc_pkg::ST_LERP : cpsc_pkg::ST_READ;
      cpsc_pkg::ST_LERP:
        if (out_free) state_nxt = cpsc_pkg::ST_OUT;
      cpsc_pkg::ST_OUT: state_nxt = cpsc_pkg::ST_IDLE;
      default: state_nxt = cpsc_pkg::ST_IDLE;
    endcase
  end

  cpsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] s,
      input logic signed [CB:0] d, input logic [TB-1:0] t);
    logic signed [CB+TB+1:0] p;
    begin
      p = $signed({1'b0, t}) * d + $signed((CB+TB+2)'(1) << (cpsc_pkg::T_FRAC - 1));
      lerp = s + CB'(p >>> cpsc_pkg::T_FRAC);
    end
  endfunction

  logic vis;
  assign vis = !reject_r && (tl_r >= te_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpsc_pkg::ST_IDLE;
      count_r <= 5'd3;
      out_valid_r <= 1'b0;
      i_r <= '0;
      reject_r <= 1'b0;
      dpos_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) count_r <= cfg_ch.data;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        cpsc_pkg::ST_IDLE:
          if (in_fire) begin
            i_r <= '0;
            reject_r <= 1'b0;
            te_r <= '0;
            tl_r <= cpsc_pkg::T_ONE;
            sx_r <= in_ch.data.start_x;
            sy_r <= in_ch.data.start_y;
            dx_r <= $signed({in_ch.data.end_x[CB-1], in_ch.data.end_x})
                  - $signed({in_ch.data.start_x[CB-1], in_ch.data.start_x});
            dy_r <= $signed({in_ch.data.end_y[CB-1], in_ch.data.end_y})
                  - $signed({in_ch.data.start_y[CB-1], in_ch.data.start_y});
          end
        cpsc_pkg::ST_DOT: begin
          num_r <= num_c;
          den_r <= den_c;
        end
        cpsc_pkg::ST_DIV: begin
          dpos_r <= den_r > 0;
          if (den_r == 0 && num_r < 0) reject_r <= 1'b1;
          if (den_r > 0 && neg_num > den_r) reject_r <= 1'b1;
          if (den_r > 0 && neg_num == den_r) te_r <= cpsc_pkg::T_ONE;
          if (den_r < 0 && num_r < 0) reject_r <= 1'b1;
        end
        cpsc_pkg::ST_NEXT:
          if (!drsp.busy) i_r <= i_r + 1'b1;
        cpsc_pkg::ST_LERP:
          if (out_free) begin
            out_r.visible <= vis;
            out_r.clip_start_x <= vis ? lerp(sx_r, dx_r, te_r) : '0;
            out_r.clip_start_y <= vis ? lerp(sy_r, dy_r, te_r) : '0;
            out_r.clip_end_x <= vis ? lerp(sx_r, dx_r, tl_r) : '0;
            out_r.clip_end_y <= vis ? lerp(sy_r, dy_r, tl_r) : '0;
          end
        cpsc_pkg::ST_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
      if (drsp.done) begin
        if (dpos_r) begin
          if (drsp.q > te_r) te_r <= drsp.q;
        end else if (drsp.q < tl_r) tl_r <= drsp.q;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_r != cpsc_pkg::ST_IDLE, !in_ch.ready)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r)
  `ASSERT_NEXT(a_out_after, clk, rst_n, state_r == cpsc_pkg::ST_OUT, out_valid_r)
endmodule

[hdl/cpsc_div.sv]
// Restoring divider giving round(a * 2^16 / b) for 0 <= a < b, one bit per cycle.
module cpsc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  cpsc_pkg::div_req_t  req,
  output cpsc_pkg::div_rsp_t  rsp
);
  localparam int CB = $clog2(cpsc_pkg::T_FRAC + 2);
  logic [cpsc_pkg::DOT_BITS:0] r_r, r_nxt;
  logic [cpsc_pkg::DOT_BITS-1:0] b_r;
  logic [cpsc_pkg::T_BITS-1:0] q_r, q_nxt;
  logic [CB-1:0] cnt_r;
  logic busy_r, done_r;
  logic [cpsc_pkg::DOT_BITS:0] sh;
  logic [cpsc_pkg::DOT_BITS+1:0] r2;

  always_comb begin
    sh = r_r << 1;
    r_nxt = sh;
    q_nxt = q_r << 1;
    if (sh >= {1'b0, b_r}) begin
      r_nxt = sh - {1'b0, b_r};
      q_nxt[0] = 1'b1;
    end
    r2 = {r_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        r_r <= {1'b0, req.a};
        b_r <= req.b;
        q_r <= '0;
      end else if (busy_r) begin
        if (cnt_r == CB'(cpsc_pkg::T_FRAC)) begin
          if (r2 >= {2'b0, b_r}) q_r <= q_r + 1'b1;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          r_r <= r_nxt;
          q_r <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.q = q_r;
endmodule
